// ===== src/ptpm_pkg.sv =====
// Shared types, codes and default sizes for the priority table.
`default_nettype none
package ptpm_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int ENTRIES_DEF       = 16;
    localparam int PRIORITY_BITS_DEF = 16;
    localparam int PAYLOAD_BITS_DEF  = 32;

    // Operation codes carried by the input item.
    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_PROMOTE = 3'd1,
        OP_POP     = 3'd2,
        OP_PEEK    = 3'd3,
        OP_LOOKUP  = 3'd4
    } t_op;

    // Status codes carried by the result item.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_DRAIN  = 2'd2,
        S_FINISH = 2'd3
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic step;
        logic load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== src/ptpm_ctrl.sv =====
// Controller state machine that sequences the table scan and the update.
`default_nettype none
module ptpm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  ptpm_pkg::t_dp_stat     i_stat,
    output ptpm_pkg::t_dp_cmd      o_cmd
);
    import ptpm_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/ptpm_dp.sv =====
// Datapath: entry memories, valid bits, scan compare and result register.
`default_nettype none
module ptpm_dp #(
    parameter int ENTRIES       = ptpm_pkg::ENTRIES_DEF,
    parameter int PRIORITY_BITS = ptpm_pkg::PRIORITY_BITS_DEF,
    parameter int PAYLOAD_BITS  = ptpm_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  ptpm_pkg::t_dp_cmd   i_cmd,
    output ptpm_pkg::t_dp_stat  o_stat,
    input  wire logic [2:0]     i_operation,
    input  wire logic [31:0]    i_payload,
    input  wire logic [31:0]    i_item_id,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [1:0]          o_status,
    output logic [31:0]         o_result_id,
    output logic [31:0]         o_payload_out,
    output logic [15:0]         o_priority_out,
    output logic                o_is_present
);
    import ptpm_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    // Entry storage.
    logic [31:0]              mem_key  [ENTRIES];
    logic [PRIORITY_BITS-1:0] mem_lvl  [ENTRIES];
    logic [PAYLOAD_BITS-1:0]  mem_data [ENTRIES];
    logic [ENTRIES-1:0]       r_valid;
    logic [31:0]              r_next_id;

    // Latched item.
    logic [2:0]  r_op;
    logic [31:0] r_payload;
    logic [31:0] r_id;

    // Scan pointer and read pipeline.
    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         r_idx_d;
    logic                     r_pipe_vld;
    logic                     r_rd_vld;
    logic [31:0]              r_rd_key;
    logic [PRIORITY_BITS-1:0] r_rd_lvl;
    logic [PAYLOAD_BITS-1:0]  r_rd_data;

    // Best candidate found so far.
    logic                     r_found;
    logic [IDX_W-1:0]         r_slot;
    logic [31:0]              r_best_key;
    logic [PRIORITY_BITS-1:0] r_best_lvl;
    logic [PAYLOAD_BITS-1:0]  r_best_data;

    // Result register.
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [31:0] r_result_id;
    logic [31:0] r_payload_out;
    logic [15:0] r_priority_out;
    logic        r_is_present;

    logic                     take;
    logic                     is_add;
    logic                     is_find;
    logic                     is_max;
    logic                     is_pop;
    logic                     is_promote;
    logic                     is_lookup;
    logic                     do_write;
    logic                     wr_key;
    logic                     wr_lvl;
    logic [PRIORITY_BITS-1:0] lvl_wdata;
    logic [PAYLOAD_BITS-1:0]  data_wdata;
    logic [63:0]              payload_wide;
    logic [63:0]              best_data_wide;
    logic [31:0]              best_lvl_wide;

    assign is_add     = (r_op == OP_ADD);
    assign is_promote = (r_op == OP_PROMOTE);
    assign is_lookup  = (r_op == OP_LOOKUP);
    assign is_pop     = (r_op == OP_POP);
    assign is_find    = is_promote || is_lookup;
    assign is_max     = is_pop || (r_op == OP_PEEK);

    // Status toward the controller.
    assign o_stat.scan_last = (r_idx == IDX_W'(ENTRIES - 1));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // Width adjustment of payload and level values.
    always_comb begin
        payload_wide                      = {32'd0, r_payload};
        best_data_wide                    = '0;
        best_data_wide[PAYLOAD_BITS-1:0]  = r_best_data;
        best_lvl_wide                     = '0;
        best_lvl_wide[PRIORITY_BITS-1:0]  = r_best_lvl;
    end

    // Memory write controls for the final step of an item.
    always_comb begin
        do_write   = i_cmd.load && r_found;
        wr_key     = do_write && is_add;
        wr_lvl     = do_write && (is_add || is_promote);
        data_wdata = payload_wide[PAYLOAD_BITS-1:0];
        if (is_add) begin
            lvl_wdata = '0;
        end else if (r_best_lvl == '1) begin
            lvl_wdata = r_best_lvl;
        end else begin
            lvl_wdata = r_best_lvl + PRIORITY_BITS'(1);
        end
    end

    // Key memory.
    always_ff @(posedge i_clk) begin
        if (wr_key) begin
            mem_key[r_slot] <= r_next_id;
        end
        r_rd_key <= mem_key[r_idx];
    end

    // Level memory.
    always_ff @(posedge i_clk) begin
        if (wr_lvl) begin
            mem_lvl[r_slot] <= lvl_wdata;
        end
        r_rd_lvl <= mem_lvl[r_idx];
    end

    // Payload memory.
    always_ff @(posedge i_clk) begin
        if (wr_key) begin
            mem_data[r_slot] <= data_wdata;
        end
        r_rd_data <= mem_data[r_idx];
    end

    // Valid bits and id counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_next_id <= '0;
        end else if (do_write && is_add) begin
            r_valid[r_slot] <= 1'b1;
            r_next_id       <= r_next_id + 32'd1;
        end else if (do_write && is_pop) begin
            r_valid[r_slot] <= 1'b0;
        end
    end

    // Item latch, scan pointer and read pipeline.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op      <= i_operation;
            r_payload <= i_payload;
            r_id      <= i_item_id;
        end
        r_rd_vld <= r_valid[r_idx];
        r_idx_d  <= r_idx;
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_pipe_vld <= 1'b0;
        end else begin
            r_pipe_vld <= i_cmd.step;
            if (i_cmd.start) begin
                r_idx <= '0;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // Compare one entry per cycle against the best candidate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.start) begin
            r_found <= 1'b0;
        end else if (r_pipe_vld) begin
            if ((is_add && !r_rd_vld && !r_found) ||
                (is_find && r_rd_vld && !r_found && r_rd_key == r_id) ||
                (is_max && r_rd_vld && (!r_found || r_rd_lvl > r_best_lvl ||
                    (r_rd_lvl == r_best_lvl && r_rd_key > r_best_key)))) begin
                r_found     <= 1'b1;
                r_slot      <= r_idx_d;
                r_best_key  <= r_rd_key;
                r_best_lvl  <= r_rd_lvl;
                r_best_data <= r_rd_data;
            end
        end
    end

    // Result register; holds the item until the consumer takes it.
    assign take = i_cmd.load;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (take) begin
            r_status       <= ST_OK;
            r_result_id    <= '0;
            r_payload_out  <= '0;
            r_priority_out <= '0;
            r_is_present   <= 1'b0;
            case (r_op)
                OP_ADD: begin
                    if (r_found) begin
                        r_result_id <= r_next_id;
                    end else begin
                        r_status <= ST_FULL;
                    end
                end
                OP_PROMOTE: begin
                    if (!r_found) begin
                        r_status <= ST_UNKNOWN;
                    end
                end
                OP_POP, OP_PEEK: begin
                    if (r_found) begin
                        r_result_id    <= r_best_key;
                        r_payload_out  <= best_data_wide[31:0];
                        r_priority_out <= best_lvl_wide[15:0];
                    end else begin
                        r_status <= ST_EMPTY;
                    end
                end
                OP_LOOKUP: begin
                    if (r_found) begin
                        r_payload_out <= best_data_wide[31:0];
                        r_is_present  <= 1'b1;
                    end else begin
                        r_status <= ST_UNKNOWN;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_result_id    = r_result_id;
    assign o_payload_out  = r_payload_out;
    assign o_priority_out = r_priority_out;
    assign o_is_present   = r_is_present;

endmodule
`default_nettype wire

// ===== src/priority_table_promote_popmax.sv =====
// Top level of the priority table with promote and pop-max operations.
//
//   Channel  | Handshake                | Payload
//   ---------+--------------------------+---------------------------------------------
//   input    | i_in_valid / o_in_ready  | i_operation, i_payload, i_item_id
//   output   | o_out_valid / i_out_ready| o_status, o_result_id, o_payload_out,
//            |                          | o_priority_out, o_is_present
//
// Every item walks the whole table, one entry per cycle through the registered
// read port of the entry memories, before the next item is taken. The result
// sits in an output register, so the next item is taken while it waits.
// Reset clears the valid bits and the id counter at once; no clearing pass.
// A stalled output holds the finishing item until the register frees up.
`default_nettype none
module priority_table_promote_popmax #(
    parameter int ENTRIES       = ptpm_pkg::ENTRIES_DEF,
    parameter int PRIORITY_BITS = ptpm_pkg::PRIORITY_BITS_DEF,
    parameter int PAYLOAD_BITS  = ptpm_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_operation,
    input  wire logic [31:0] i_payload,
    input  wire logic [31:0] i_item_id,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [31:0]      o_result_id,
    output logic [31:0]      o_payload_out,
    output logic [15:0]      o_priority_out,
    output logic             o_is_present
);
    import ptpm_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer.
    ptpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Table storage and compare logic.
    ptpm_dp #(
        .ENTRIES       (ENTRIES),
        .PRIORITY_BITS (PRIORITY_BITS),
        .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_operation    (i_operation),
        .i_payload      (i_payload),
        .i_item_id      (i_item_id),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_result_id    (o_result_id),
        .o_payload_out  (o_payload_out),
        .o_priority_out (o_priority_out),
        .o_is_present   (o_is_present)
    );

endmodule
`default_nettype wire
